FILE: rtl/dcbt_pkg.sv
// Package for the device channel binding table.
// Holds the fixed field widths, the stored entry type and the structs
// passed between the sequencer, the entry store and the top level.
package dcbt_pkg;

  localparam int ID_W       = 32;
  localparam int TIME_W     = 32;
  localparam int CH_W       = 7;
  localparam int BASE_W     = 6;
  localparam logic [BASE_W-1:0] BASE_RESET = 6'd36;

  // One binding as it sits in the store.
  typedef struct packed {
    logic [ID_W-1:0]   dev_id;
    logic [TIME_W-1:0] tstamp;
    logic [CH_W-1:0]   ch;
  } entry_t;

  // Write request from the sequencer to the store.
  typedef struct packed {
    logic   en;
    entry_t data;
  } mem_wr_t;

  // Finished result handed from the sequencer to the output register.
  typedef struct packed {
    logic            load;
    logic [CH_W-1:0] channel;
    logic            hit;
    logic            evicted;
  } result_t;

endpackage

FILE: rtl/dcbt_channels.sv
// Valid/ready channel interfaces for the device channel binding table.
// Depends on dcbt_pkg for the field widths.
interface dcbt_req_if;
  import dcbt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ID_W-1:0]   device_id;
  logic        [TIME_W-1:0] now;

  modport source (output valid, output device_id, output now, input ready);
  modport sink (input valid, input device_id, input now, output ready);
endinterface

interface dcbt_rsp_if;
  import dcbt_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] channel;
  logic            hit;
  logic            evicted;

  modport source (output valid, output channel, output hit, output evicted, input ready);
  modport sink (input valid, input channel, input hit, input evicted, output ready);
endinterface

FILE: rtl/dcbt_store.sv
// Binding store: one write port and one read port with registered data.
// Depends on dcbt_pkg for the entry type.
module dcbt_store #(
  parameter int TABLE_ENTRIES = 7,
  parameter int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic             clk,
  input  logic [IDX_W-1:0] rd_addr,
  output dcbt_pkg::entry_t rd_data,
  input  logic [IDX_W-1:0] wr_addr,
  input  dcbt_pkg::mem_wr_t wr
);
  import dcbt_pkg::*;

  entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/dcbt_seq.sv
// Sequencer of the binding table: scans the store for a match and the
// oldest entry in one pass, then appends or evicts, shifts and appends.
// Depends on dcbt_pkg; drives the ports of dcbt_store.
module dcbt_seq #(
  parameter int TABLE_ENTRIES = 7,
  parameter int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  parameter int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [dcbt_pkg::ID_W-1:0]   req_id,
  input  logic [dcbt_pkg::TIME_W-1:0] req_now,
  input  logic [dcbt_pkg::BASE_W-1:0] channel_base,
  input  logic                        out_free,
  output logic [IDX_W-1:0]            rd_addr,
  input  dcbt_pkg::entry_t            rd_data,
  output logic [IDX_W-1:0]            wr_addr,
  output dcbt_pkg::mem_wr_t           wr,
  output dcbt_pkg::result_t           res
);
  import dcbt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_MISS   = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_SHLAST = 3'd4;
  localparam logic [2:0] S_APPEND = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_ENTRIES);

  logic [2:0]        state;
  logic [CNT_W-1:0]  count;
  logic [ID_W-1:0]   cur_id;
  logic [TIME_W-1:0] cur_now;
  logic [CNT_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  scan_idx;
  logic              scan_vld;
  logic [TIME_W-1:0] min_time;
  logic [IDX_W-1:0]  min_idx;
  logic [CH_W-1:0]   min_ch;
  logic [IDX_W-1:0]  sh_src;
  logic [IDX_W-1:0]  sh_dst;
  logic              sh_pend;
  logic [CH_W-1:0]   res_ch;
  logic              res_hit;
  logic              res_ev;

  logic              scan_issue;
  logic              is_min;
  logic [CH_W-1:0]   ch_new;

  assign req_ready  = (state == S_IDLE);
  assign scan_issue = (state == S_SCAN) && (rd_idx < count);
  assign is_min     = (scan_idx == '0) || (rd_data.tstamp < min_time);
  assign ch_new     = CH_W'(channel_base) + CH_W'(count);

  assign res.load    = (state == S_DONE) && out_free;
  assign res.channel = res_ch;
  assign res.hit     = res_hit;
  assign res.evicted = res_ev;

  always_comb begin
    rd_addr     = rd_idx[IDX_W-1:0];
    wr_addr     = sh_dst;
    wr.en       = 1'b0;
    wr.data     = rd_data;
    unique case (state)
      S_SHIFT: begin
        rd_addr = sh_src;
        wr.en   = sh_pend;
      end
      S_SHLAST: begin
        wr.en = 1'b1;
      end
      S_MISS: begin
        wr_addr        = count[IDX_W-1:0];
        wr.en          = (count < FULL);
        wr.data.dev_id = cur_id;
        wr.data.tstamp = cur_now;
        wr.data.ch     = ch_new;
      end
      S_APPEND: begin
        wr_addr        = LAST;
        wr.en          = 1'b1;
        wr.data.dev_id = cur_id;
        wr.data.tstamp = cur_now;
        wr.data.ch     = min_ch;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      scan_vld <= 1'b0;
      sh_pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur_id   <= req_id;
            cur_now  <= req_now;
            rd_idx   <= '0;
            scan_vld <= 1'b0;
            state    <= (count == '0) ? S_MISS : S_SCAN;
          end
        end
        S_SCAN: begin
          // Reads run one entry ahead of the compare on the registered data.
          if (scan_issue) begin
            rd_idx <= rd_idx + CNT_W'(1);
          end
          scan_vld <= scan_issue;
          scan_idx <= rd_idx;
          if (scan_vld) begin
            if (is_min) begin
              min_time <= rd_data.tstamp;
              min_idx  <= scan_idx[IDX_W-1:0];
              min_ch   <= rd_data.ch;
            end
            if (rd_data.dev_id == cur_id) begin
              res_ch  <= rd_data.ch;
              res_hit <= 1'b1;
              res_ev  <= 1'b0;
              state   <= S_DONE;
            end else if (scan_idx == count - CNT_W'(1)) begin
              state <= S_MISS;
            end
          end
        end
        S_MISS: begin
          res_hit <= 1'b0;
          if (count < FULL) begin
            res_ch <= ch_new;
            res_ev <= 1'b0;
            count  <= count + CNT_W'(1);
            state  <= S_DONE;
          end else begin
            res_ch  <= min_ch;
            res_ev  <= 1'b1;
            sh_src  <= min_idx + IDX_W'(1);
            sh_pend <= 1'b0;
            state   <= (min_idx == LAST) ? S_APPEND : S_SHIFT;
          end
        end
        S_SHIFT: begin
          sh_dst  <= sh_src - IDX_W'(1);
          sh_pend <= 1'b1;
          if (sh_src == LAST) begin
            state <= S_SHLAST;
          end else begin
            sh_src <= sh_src + IDX_W'(1);
          end
        end
        S_SHLAST: begin
          sh_pend <= 1'b0;
          state   <= S_APPEND;
        end
        S_APPEND: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/device_channel_binding_table_top.sv
// Top level of the device channel binding table.
// Depends on dcbt_pkg, dcbt_channels, dcbt_store and dcbt_seq.
//
// The req channel carries one word per device request: device_id and now.
// The rsp channel returns one word for each request: channel, hit and
// evicted. Both follow valid/ready; a word moves when both are high.
// cfg_we writes cfg_wdata into channel_base, the first channel handed out;
// the user must write it only while the block is idle; no check enforces it.
//
// One request at a time: req.ready is high only while the sequencer is idle.
// The sequencer reads one entry per cycle from the store and checks it for a
// match and for the oldest time in the same pass. A hit on entry k ends the
// scan there. A miss with room appends a new binding after the scan, or at
// once when the table is empty. A miss on a full table evicts the oldest
// entry and adds the shift that closes the gap and the append. The single
// store read port sets the scan rate.
// Reset empties the table and sets channel_base to 36. The response sits in
// an output register; a new request is taken while it waits, and the
// sequencer holds its next result until that register is free.
module device_channel_binding_table_top #(
  parameter int TABLE_ENTRIES = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  dcbt_req_if.sink                    req,
  dcbt_rsp_if.source                  rsp,
  input  logic                        cfg_we,
  input  logic [dcbt_pkg::BASE_W-1:0] cfg_wdata
);
  import dcbt_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic [BASE_W-1:0] channel_base;
  logic              rsp_valid;
  logic [CH_W-1:0]   rsp_channel;
  logic              rsp_hit;
  logic              rsp_evicted;
  logic              out_free;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            rd_data;
  mem_wr_t           wr;
  result_t           res;

  assign out_free    = !rsp_valid || rsp.ready;
  assign rsp.valid   = rsp_valid;
  assign rsp.channel = rsp_channel;
  assign rsp.hit     = rsp_hit;
  assign rsp.evicted = rsp_evicted;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_base <= BASE_RESET;
    end else if (cfg_we) begin
      channel_base <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res.load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      rsp_channel <= res.channel;
      rsp_hit     <= res.hit;
      rsp_evicted <= res.evicted;
    end
  end

  dcbt_store #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IDX_W(IDX_W)
  ) u_store (
    .clk(clk),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_addr(wr_addr),
    .wr(wr)
  );

  dcbt_seq #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IDX_W(IDX_W),
    .CNT_W(CNT_W)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .req_id(req.device_id),
    .req_now(req.now),
    .channel_base(channel_base),
    .out_free(out_free),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_addr(wr_addr),
    .wr(wr),
    .res(res)
  );

  // A hit never removes a binding.
  a_hit_not_evict: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.hit && rsp.evicted))
    else $error("response reports both hit and eviction");

  // The sequencer is busy in the cycle after it takes a request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while the previous one is still in work");

  // A new response is only loaded from a busy sequencer.
  a_load_from_busy: assert property (@(posedge clk) disable iff (rst)
    res.load |-> !req.ready)
    else $error("response loaded while the sequencer is idle");

  // The output register is never overwritten while a response waits.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |-> !res.load)
    else $error("waiting response overwritten");

endmodule
